>>> design/pyu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pyu_pkg
// Shared types and constants of the damped Yee field update block.
// ----------------------------------------------------------------------------
package pyu_pkg;

    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CENTER_W    = 14;
    localparam int INV_W       = 24;
    localparam int LIM_W       = 16;
    localparam int FIELD_W     = 32;
    localparam int COEFF_W     = 17;
    localparam int CURL_W      = 35;
    localparam int M_W         = 17;
    localparam int SQ_W        = 34;
    localparam int SQ_REM_W    = 20;
    localparam int ROOT_W      = 17;
    localparam int Q_W         = 16;
    localparam int MAG_W       = 16;
    localparam int A_W         = 18;
    localparam int FAC_W       = 20;
    localparam int CC_W        = 52;
    localparam int PF_W        = 52;
    localparam int NUM_W       = 56;
    localparam int DEN_W       = 19;
    localparam int QUO_W       = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [M_W-1:0]     ONE_Q16 = 17'h10000;
    localparam logic [DEN_W-1:0]   ONE_Q18 = 19'h40000;
    localparam logic [FIELD_W-1:0] INT_MAX = 32'h7fffffff;
    localparam logic [FIELD_W-1:0] INT_MIN = 32'h80000000;

    localparam logic [1:0] PROFILE_SPHERE = 2'd0;
    localparam logic [1:0] PROFILE_CYL_X  = 2'd1;
    localparam logic [1:0] PROFILE_CYL_Z  = 2'd2;

    localparam logic [1:0] OP_ELECTRIC = 2'd0;
    localparam logic [1:0] OP_HALF_MAG = 2'd1;
    localparam logic [1:0] OP_COUPLED  = 2'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PROFILE_MODE = 3'd0,
        REG_CENTER_X     = 3'd1,
        REG_CENTER_Y     = 3'd2,
        REG_CENTER_Z     = 3'd3,
        REG_INV_RADIUS_X = 3'd4,
        REG_INV_RADIUS_Y = 3'd5,
        REG_INV_RADIUS_Z = 3'd6,
        REG_RADIUS_LIMIT = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_ELECTRIC,
        KIND_HALF_MAG,
        KIND_COUPLED
    } kind_t;

    typedef struct packed {
        logic [1:0]       profile_mode;
        logic [INV_W-1:0] inv_x;
        logic [INV_W-1:0] inv_y;
        logic [INV_W-1:0] inv_z;
        logic [LIM_W-1:0] radius_limit;
    } cfg_t;

    typedef struct packed {
        kind_t                     kind;
        logic [M_W-1:0]            mx;
        logic [M_W-1:0]            my;
        logic [M_W-1:0]            mz;
        logic signed [FIELD_W-1:0] f;
        logic signed [CURL_W-1:0]  curl;
        logic [COEFF_W-1:0]        coeff;
    } item_t;

    typedef struct packed {
        kind_t                     kind;
        logic signed [FIELD_W-1:0] f;
        logic signed [CC_W-1:0]    cc;
        logic                      lim_zero;
        logic                      lim_sat;
    } carry_t;

    typedef struct packed {
        logic [SQ_W-1:0]     v;
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
    } sq_t;

    typedef struct packed {
        logic [M_W-1:0] rem;
        logic [Q_W-1:0] quo;
    } qd_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             ovf;
    } dv_t;

endpackage

>>> design/pyu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pyu_front
// Intake stages: classify the pass, form axis offsets, scale and clamp them,
// and pre-sum the curl terms.
// ----------------------------------------------------------------------------
module pyu_front
    import pyu_pkg::*;
#(
    parameter int COORD_BITS = 14
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic [COORD_BITS-1:0]     center_x,
    input  logic [COORD_BITS-1:0]     center_y,
    input  logic [COORD_BITS-1:0]     center_z,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                op,
    input  logic [COORD_BITS-1:0]     pos_x2,
    input  logic [COORD_BITS-1:0]     pos_y2,
    input  logic [COORD_BITS-1:0]     pos_z2,
    input  logic signed [FIELD_W-1:0] field_old,
    input  logic signed [FIELD_W-1:0] curl_a,
    input  logic signed [FIELD_W-1:0] curl_b,
    input  logic signed [FIELD_W-1:0] curl_c,
    input  logic signed [FIELD_W-1:0] curl_d,
    input  logic [COEFF_W-1:0]        curl_coeff,
    output item_t                     out_item,
    output logic                      out_valid,
    input  logic                      out_ready
);

    localparam int PROD_W = COORD_BITS + INV_W;
    localparam int SH_W   = PROD_W - 8;

    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] p,
        input logic [COORD_BITS-1:0] c
    );
        return (p >= c) ? (p - c) : (c - p);
    endfunction

    function automatic logic [M_W-1:0] scale(
        input logic [COORD_BITS-1:0] d,
        input logic [INV_W-1:0]      inv
    );
        logic [PROD_W-1:0] prod;
        logic [SH_W-1:0]   sh;
        prod = PROD_W'(d) * PROD_W'(inv);
        sh   = prod[PROD_W-1:8];
        return (sh > SH_W'(ONE_Q16)) ? ONE_Q16 : sh[M_W-1:0];
    endfunction

    logic                       adv;
    logic                       f1_vld_reg;
    logic                       f2_vld_reg;
    logic [COORD_BITS-1:0]      dx_reg;
    logic [COORD_BITS-1:0]      dy_reg;
    logic [COORD_BITS-1:0]      dz_reg;
    kind_t                      kind_reg;
    kind_t                      kind_next;
    logic signed [FIELD_W-1:0]  f_reg;
    logic signed [FIELD_W:0]    ab_reg;
    logic signed [FIELD_W:0]    dc_reg;
    logic [COEFF_W-1:0]         coeff_reg;
    item_t                      item_reg;
    item_t                      item_next;

    assign adv       = !f2_vld_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = f2_vld_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        case (op)
            OP_ELECTRIC: kind_next = KIND_ELECTRIC;
            OP_HALF_MAG: kind_next = KIND_HALF_MAG;
            default:     kind_next = KIND_COUPLED;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_vld_reg <= in_valid;
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg    <= abs_diff(pos_x2, center_x);
            dy_reg    <= abs_diff(pos_y2, center_y);
            dz_reg    <= abs_diff(pos_z2, center_z);
            kind_reg  <= kind_next;
            f_reg     <= field_old;
            ab_reg    <= (FIELD_W+1)'(curl_a) - (FIELD_W+1)'(curl_b);
            dc_reg    <= (FIELD_W+1)'(curl_d) - (FIELD_W+1)'(curl_c);
            coeff_reg <= curl_coeff;
        end
    end

    always_comb
    begin
        item_next.kind  = kind_reg;
        item_next.mx    = scale(dx_reg, cfg.inv_x);
        item_next.my    = scale(dy_reg, cfg.inv_y);
        item_next.mz    = scale(dz_reg, cfg.inv_z);
        item_next.f     = f_reg;
        item_next.curl  = CURL_W'(ab_reg) + CURL_W'(dc_reg);
        item_next.coeff = coeff_reg;
        if (cfg.profile_mode == PROFILE_CYL_X)
        begin
            item_next.mx = '0;
        end
        else if (cfg.profile_mode == PROFILE_CYL_Z)
        begin
            item_next.mz = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

endmodule

>>> design/pyu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pyu_queue
// Short FIFO between intake and arithmetic stages.
// ----------------------------------------------------------------------------
module pyu_queue
    import pyu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  item_t in_item,
    input  logic  in_valid,
    output logic  in_ready,
    output item_t out_item,
    output logic  out_valid,
    input  logic  out_ready
);

    item_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               push;
    logic               pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> design/pyu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pyu_back
// Arithmetic pipeline: radius, damping profile, update numerator, signed
// division and saturation.
// ----------------------------------------------------------------------------
module pyu_back
    import pyu_pkg::*;
#(
    parameter int DAMP_MAX = 52429
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  item_t              in_item,
    input  logic               in_valid,
    output logic               in_ready,
    output logic [FIELD_W-1:0] out_data,
    output logic               out_valid,
    input  logic               out_ready
);

    localparam int SQ_STEPS  = ROOT_W;
    localparam int QD_STEPS  = Q_W;
    localparam int DV_STEPS  = QUO_W;
    localparam int L_IDX     = 2 + SQ_STEPS;
    localparam int CARRY_LEN = L_IDX + 1 + QD_STEPS + 3;
    localparam int N_STAGES  = CARRY_LEN + 1 + 4 + DV_STEPS + 1;
    localparam logic [MAG_W-1:0] DMAX = MAG_W'(DAMP_MAX);

    logic                  adv;
    logic [N_STAGES-1:0]   vld_reg;
    carry_t                carry_reg [CARRY_LEN];

    assign adv       = !vld_reg[N_STAGES-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[N_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[N_STAGES-2:0], in_valid};
        end
    end

    // squares of scaled offsets, curl times coefficient
    logic [SQ_W-1:0]         sx_reg;
    logic [SQ_W-1:0]         sy_reg;
    logic [SQ_W-1:0]         sz_reg;
    logic [SQ_W-1:0]         sum_reg;
    logic signed [CC_W:0]    cc_full;

    assign cc_full = $signed({1'b0, in_item.coeff}) * in_item.curl;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx_reg  <= SQ_W'(in_item.mx) * SQ_W'(in_item.mx);
            sy_reg  <= SQ_W'(in_item.my) * SQ_W'(in_item.my);
            sz_reg  <= SQ_W'(in_item.mz) * SQ_W'(in_item.mz);
            sum_reg <= sx_reg + sy_reg + sz_reg;
        end
    end

    // radius test results, fed into the carry line
    sq_t                sq_reg [SQ_STEPS];
    logic [M_W-1:0]     qden;
    logic [M_W-1:0]     r_root;
    logic [M_W-1:0]     ldiff_next;
    logic [M_W-1:0]     ldiff_reg;
    logic               lzero_next;
    logic               lsat_next;

    assign qden       = ONE_Q16 - M_W'(cfg.radius_limit);
    assign r_root     = sq_reg[SQ_STEPS-1].root;
    assign ldiff_next = r_root - M_W'(cfg.radius_limit);
    assign lzero_next = (r_root <= M_W'(cfg.radius_limit));
    assign lsat_next  = (ldiff_next >= qden);

    for (genvar k = 0; k < CARRY_LEN; k++)
    begin : g_carry
        if (k == 0)
        begin : g_head
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    carry_reg[k].kind     <= in_item.kind;
                    carry_reg[k].f        <= in_item.f;
                    carry_reg[k].cc       <= cc_full[CC_W-1:0];
                    carry_reg[k].lim_zero <= 1'b0;
                    carry_reg[k].lim_sat  <= 1'b0;
                end
            end
        end
        else if (k == L_IDX)
        begin : g_lim
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    carry_reg[k].kind     <= carry_reg[k-1].kind;
                    carry_reg[k].f        <= carry_reg[k-1].f;
                    carry_reg[k].cc       <= carry_reg[k-1].cc;
                    carry_reg[k].lim_zero <= lzero_next;
                    carry_reg[k].lim_sat  <= lsat_next;
                end
            end
        end
        else
        begin : g_pass
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    carry_reg[k] <= carry_reg[k-1];
                end
            end
        end
    end

    // integer square root, one result bit per stage
    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_sqrt
        sq_t                 prev;
        sq_t                 nxt;
        logic [SQ_REM_W-1:0] rem_sh;
        logic [SQ_REM_W-1:0] trial;

        if (i == 0)
        begin : g_first
            assign prev = '{v: sum_reg, rem: '0, root: '0};
        end
        else
        begin : g_rest
            assign prev = sq_reg[i-1];
        end

        always_comb
        begin
            rem_sh = {prev.rem[SQ_REM_W-3:0], prev.v[SQ_W-1 -: 2]};
            trial  = {1'b0, prev.root, 2'b01};
            nxt.v  = {prev.v[SQ_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                nxt.rem  = rem_sh - trial;
                nxt.root = {prev.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                nxt.rem  = rem_sh;
                nxt.root = {prev.root[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_reg[i] <= nxt;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ldiff_reg <= ldiff_next;
        end
    end

    // profile fraction (r - lim) / (1 - lim), one quotient bit per stage
    qd_t qd_reg [QD_STEPS];

    for (genvar i = 0; i < QD_STEPS; i++)
    begin : g_qdiv
        qd_t            prev;
        qd_t            nxt;
        logic [M_W:0]   rem_sh;
        logic           ge;

        if (i == 0)
        begin : g_first
            assign prev = '{rem: ldiff_reg, quo: '0};
        end
        else
        begin : g_rest
            assign prev = qd_reg[i-1];
        end

        always_comb
        begin
            rem_sh  = {prev.rem, 1'b0};
            ge      = (rem_sh >= {1'b0, qden});
            nxt.rem = ge ? M_W'(rem_sh - {1'b0, qden}) : M_W'(rem_sh);
            nxt.quo = {prev.quo[Q_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                qd_reg[i] <= nxt;
            end
        end
    end

    // cube and scale to magnitude
    logic [2*Q_W-1:0]   qq_reg;
    logic [Q_W-1:0]     q1_reg;
    logic [3*Q_W-1:0]   qqq;
    logic [Q_W-1:0]     cube_reg;
    logic [2*MAG_W-1:0] mprod;
    logic [MAG_W-1:0]   mag_next;
    logic [MAG_W-1:0]   mag_reg;

    assign qqq   = (3*Q_W)'(qq_reg) * (3*Q_W)'(q1_reg);
    assign mprod = (2*MAG_W)'(DMAX) * (2*MAG_W)'(cube_reg);

    always_comb
    begin
        if (carry_reg[CARRY_LEN-2].lim_zero)
        begin
            mag_next = '0;
        end
        else if (carry_reg[CARRY_LEN-2].lim_sat)
        begin
            mag_next = DMAX;
        end
        else if (mprod[2*MAG_W-1:MAG_W] > DMAX)
        begin
            mag_next = DMAX;
        end
        else
        begin
            mag_next = mprod[2*MAG_W-1:MAG_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qq_reg   <= (2*Q_W)'(qd_reg[QD_STEPS-1].quo) * (2*Q_W)'(qd_reg[QD_STEPS-1].quo);
            q1_reg   <= qd_reg[QD_STEPS-1].quo;
            cube_reg <= qqq[3*Q_W-1:2*Q_W];
            mag_reg  <= mag_next;
        end
    end

    // damping factor, numerator, magnitude split
    logic [A_W-1:0]            a_val;
    logic signed [FAC_W-1:0]   fac_next;
    logic signed [FAC_W-1:0]   fac_reg;
    logic [DEN_W-1:0]          den_a_reg;
    logic signed [FIELD_W-1:0] f_a_reg;
    logic signed [CC_W-1:0]    cc_a_reg;
    logic signed [PF_W-1:0]    pf_reg;
    logic [DEN_W-1:0]          den_n1_reg;
    logic signed [CC_W-1:0]    cc_n1_reg;
    logic signed [NUM_W-1:0]   num_reg;
    logic [DEN_W-1:0]          den_n2_reg;
    logic [NUM_W-1:0]          absn_reg;
    logic                      neg_reg;
    logic [DEN_W-1:0]          den_n3_reg;
    dv_t                       n4_reg;
    carry_t                    ca;

    assign ca    = carry_reg[CARRY_LEN-1];
    assign a_val = (ca.kind == KIND_HALF_MAG) ? {2'b00, mag_reg} : {1'b0, mag_reg, 1'b0};

    always_comb
    begin
        if (ca.kind == KIND_COUPLED)
        begin
            fac_next = -$signed(FAC_W'(a_val));
        end
        else
        begin
            fac_next = $signed(FAC_W'(ONE_Q18)) - $signed(FAC_W'(a_val));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fac_reg    <= fac_next;
            den_a_reg  <= ONE_Q18 + DEN_W'(a_val);
            f_a_reg    <= ca.f;
            cc_a_reg   <= ca.cc;
            pf_reg     <= PF_W'(f_a_reg) * PF_W'(fac_reg);
            den_n1_reg <= den_a_reg;
            cc_n1_reg  <= cc_a_reg;
            num_reg    <= NUM_W'(pf_reg) + (NUM_W'(cc_n1_reg) <<< 2);
            den_n2_reg <= den_n1_reg;
            neg_reg    <= num_reg[NUM_W-1];
            absn_reg   <= num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
            den_n3_reg <= den_n2_reg;
            n4_reg.rem <= absn_reg;
            n4_reg.den <= den_n3_reg;
            n4_reg.quo <= '0;
            n4_reg.neg <= neg_reg;
            n4_reg.ovf <= (absn_reg >= (NUM_W'(den_n3_reg) << QUO_W));
        end
    end

    // unsigned division of the numerator magnitude, one bit per stage
    dv_t dv_reg [DV_STEPS];

    for (genvar i = 0; i < DV_STEPS; i++)
    begin : g_div
        dv_t              prev;
        dv_t              nxt;
        logic [NUM_W-1:0] sub;
        logic             ge;

        if (i == 0)
        begin : g_first
            assign prev = n4_reg;
        end
        else
        begin : g_rest
            assign prev = dv_reg[i-1];
        end

        always_comb
        begin
            sub     = NUM_W'(prev.den) << (DV_STEPS - 1 - i);
            ge      = (prev.rem >= sub);
            nxt     = prev;
            nxt.rem = ge ? (prev.rem - sub) : prev.rem;
            nxt.quo = {prev.quo[QUO_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[i] <= nxt;
            end
        end
    end

    // sign and saturation
    dv_t                dv_last;
    logic [FIELD_W-1:0] res_next;
    logic [FIELD_W-1:0] res_reg;

    assign dv_last = dv_reg[DV_STEPS-1];

    always_comb
    begin
        if (dv_last.neg)
        begin
            if (dv_last.ovf || (dv_last.quo > INT_MIN))
            begin
                res_next = INT_MIN;
            end
            else
            begin
                res_next = -dv_last.quo;
            end
        end
        else
        begin
            if (dv_last.ovf || dv_last.quo[QUO_W-1])
            begin
                res_next = INT_MAX;
            end
            else
            begin
                res_next = dv_last.quo;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign out_data = res_reg;

endmodule

>>> design/pml_damped_yee_field_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pml_damped_yee_field_update
// Staggered-grid field component update with radial absorbing-layer damping.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Contents
//  s_axis   | in        | tuser: op; tdata: pos, field_old, curl_a..d, coeff
//  m_axis   | out       | tdata: field_new
//  wr       | in        | register index and write data
//
// One transaction per cycle is accepted and delivered when m_tready stays high.
// A transaction passes the intake registers, the queue and 77 arithmetic stages,
// which hold the square root, the profile divider and the 32-bit quotient divider.
// Reset clears all valid state and configuration registers.
// A low m_tready freezes the arithmetic stages; the queue then fills before
// s_tready drops.
// ----------------------------------------------------------------------------
module pml_damped_yee_field_update
    import pyu_pkg::*;
#(
    parameter int DAMP_MAX   = 52429,
    parameter int COORD_BITS = 14
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // pos_x2, pos_y2, pos_z2, field_old, curl_a, curl_b, curl_c, curl_d, curl_coeff
    input  logic [((3*COORD_BITS+5*FIELD_W+COEFF_W+7)/8)*8-1:0] s_tdata,
    // op
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // field_new
    output logic [FIELD_W-1:0]     m_tdata,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data
);

    localparam int OFS_Y  = COORD_BITS;
    localparam int OFS_Z  = 2*COORD_BITS;
    localparam int OFS_F  = 3*COORD_BITS;
    localparam int OFS_A  = OFS_F + FIELD_W;
    localparam int OFS_B  = OFS_A + FIELD_W;
    localparam int OFS_C  = OFS_B + FIELD_W;
    localparam int OFS_D  = OFS_C + FIELD_W;
    localparam int OFS_CF = OFS_D + FIELD_W;

    cfg_t                   cfg_reg;
    logic [COORD_BITS-1:0]  center_x_reg;
    logic [COORD_BITS-1:0]  center_y_reg;
    logic [COORD_BITS-1:0]  center_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg      <= '0;
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx_t'(wr_index))
                REG_PROFILE_MODE: cfg_reg.profile_mode <= wr_data[1:0];
                REG_CENTER_X:     center_x_reg <= COORD_BITS'(wr_data[CENTER_W-1:0]);
                REG_CENTER_Y:     center_y_reg <= COORD_BITS'(wr_data[CENTER_W-1:0]);
                REG_CENTER_Z:     center_z_reg <= COORD_BITS'(wr_data[CENTER_W-1:0]);
                REG_INV_RADIUS_X: cfg_reg.inv_x <= wr_data[INV_W-1:0];
                REG_INV_RADIUS_Y: cfg_reg.inv_y <= wr_data[INV_W-1:0];
                REG_INV_RADIUS_Z: cfg_reg.inv_z <= wr_data[INV_W-1:0];
                REG_RADIUS_LIMIT: cfg_reg.radius_limit <= wr_data[LIM_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    item_t front_item;
    logic  front_valid;
    logic  front_ready;
    item_t queue_item;
    logic  queue_valid;
    logic  queue_ready;

    pyu_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .center_x   (center_x_reg),
        .center_y   (center_y_reg),
        .center_z   (center_z_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .op         (s_tuser),
        .pos_x2     (s_tdata[COORD_BITS-1:0]),
        .pos_y2     (s_tdata[OFS_Y +: COORD_BITS]),
        .pos_z2     (s_tdata[OFS_Z +: COORD_BITS]),
        .field_old  (s_tdata[OFS_F +: FIELD_W]),
        .curl_a     (s_tdata[OFS_A +: FIELD_W]),
        .curl_b     (s_tdata[OFS_B +: FIELD_W]),
        .curl_c     (s_tdata[OFS_C +: FIELD_W]),
        .curl_d     (s_tdata[OFS_D +: FIELD_W]),
        .curl_coeff (s_tdata[OFS_CF +: COEFF_W]),
        .out_item   (front_item),
        .out_valid  (front_valid),
        .out_ready  (front_ready)
    );

    pyu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (front_item),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_item  (queue_item),
        .out_valid (queue_valid),
        .out_ready (queue_ready)
    );

    pyu_back #(
        .DAMP_MAX (DAMP_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_item   (queue_item),
        .in_valid  (queue_valid),
        .in_ready  (queue_ready),
        .out_data  (m_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

endmodule
